// ===== src/hbs_pkg.sv =====
// Package for the header blacklist screen: payload structs, region phase
// codes, keyword and pattern constants, and the per-region update function.
// No dependencies.
package hbs_pkg;

  localparam int WinBytes = 11;
  localparam int WinBits  = 8 * WinBytes;
  localparam int NumPat   = 8;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic verdict_good;
    logic agent_flagged;
    logic sender_flagged;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_INSIDE = 2'd1,
    PH_CLOSED = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] count;
    logic       pending;
    logic       bad;
  } region_t;

  localparam region_t RegionRst = '{phase: PH_SEARCH, count: 4'd0, pending: 1'b0, bad: 1'b0};

  localparam logic [7:0] ByteNewline = 8'h0A;
  localparam logic [7:0] ByteNul     = 8'h00;

  // Keywords, oldest character in the most significant byte.
  localparam logic [87:0] KwAgent  = "User-Agent:";
  localparam logic [39:0] KwSender = "From:";

  localparam logic [31:0] PatScan      = "scan";
  localparam logic [31:0] PatSipp      = "sipp";
  localparam logic [71:0] PatSunday    = "sundayddr";
  localparam logic [47:0] PatSipcli    = "sipcli";
  localparam logic [47:0] PatSipsak    = "sipsak";
  localparam logic [63:0] PatSipScan   = "sip-scan";
  localparam logic [31:0] PatIwar      = "iWar";
  localparam logic [79:0] PatSipvicious = "sipvicious";

  localparam logic [3:0] PatLen [NumPat] = '{4'd4, 4'd4, 4'd9, 4'd6, 4'd6, 4'd8, 4'd4, 4'd10};

  // Next state of one region for a non-zero byte; the window already holds
  // the byte. A pattern counts only once the region holds at least its length.
  function automatic region_t region_next(region_t r, logic [7:0] b, logic kw_hit,
                                          logic [NumPat-1:0] pat_match);
    region_t    n;
    logic [3:0] cnt;
    logic       hit;
    n   = r;
    cnt = (r.count == 4'hF) ? r.count : r.count + 4'd1;
    hit = 1'b0;
    for (int i = 0; i < NumPat; i++) begin
      if (pat_match[i] && (PatLen[i] <= cnt)) hit = 1'b1;
    end
    unique case (r.phase)
      PH_SEARCH: begin
        if (kw_hit) begin
          n.phase   = PH_INSIDE;
          n.count   = 4'd0;
          n.pending = 1'b0;
        end
      end
      PH_INSIDE: begin
        if (b == ByteNewline) begin
          n.phase = PH_CLOSED;
          n.bad   = r.pending;
        end else begin
          n.count = cnt;
          if (hit) n.pending = 1'b1;
        end
      end
      default: n = r;
    endcase
    return n;
  endfunction

endpackage

// ===== src/header_blacklist_screen.sv =====
// Top level of the header blacklist screen: input register, byte window,
// region trackers and result register. Depends on hbs_pkg.

// The block takes one message byte per cycle and screens the "User-Agent:"
// and "From:" header lines for known scanner-tool names. A byte transfer is
// taken every cycle while the result side keeps up. The byte marked as the
// last of the message yields one result, which is presented once it is
// registered: the input register loads at the transfer edge and the
// result register at the first later edge on which the result side is not
// stalled, with a single pass of window compare and region update between
// them. A zero byte ends the text; later bytes are ignored until the end
// of the message, and all state clears after each verdict.
module header_blacklist_screen
  import hbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic              in_vld_r, in_vld_nxt;
  in_item_t          in_data_r;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [WinBits-1:0] win_r, win_nxt;
  region_t           agent_r, agent_nxt, sender_r, sender_nxt;
  logic              ended_r, ended_nxt;

  logic              advance;
  logic              in_take;
  logic [WinBits-1:0] shifted;
  logic [NumPat-1:0] pat_match;
  logic [7:0]        b;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign b       = in_data_r.text_byte;
  assign shifted = {win_r[WinBits-9:0], b};

  always_comb begin
    pat_match[0] = shifted[31:0] == PatScan;
    pat_match[1] = shifted[31:0] == PatSipp;
    pat_match[2] = shifted[71:0] == PatSunday;
    pat_match[3] = shifted[47:0] == PatSipcli;
    pat_match[4] = shifted[47:0] == PatSipsak;
    pat_match[5] = shifted[63:0] == PatSipScan;
    pat_match[6] = shifted[31:0] == PatIwar;
    pat_match[7] = shifted[79:0] == PatSipvicious;
  end

  always_comb begin
    win_nxt      = win_r;
    agent_nxt    = agent_r;
    sender_nxt   = sender_r;
    ended_nxt    = ended_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (advance) begin
      out_vld_nxt = 1'b0;
      if (in_vld_r) begin
        if (!ended_r) begin
          if (b == ByteNul) begin
            ended_nxt = 1'b1;
          end else begin
            win_nxt    = shifted;
            agent_nxt  = region_next(agent_r, b, shifted == KwAgent, pat_match);
            sender_nxt = region_next(sender_r, b, shifted[39:0] == KwSender, pat_match);
          end
        end
        if (in_data_r.end_of_message) begin
          out_vld_nxt                 = 1'b1;
          out_data_nxt.agent_flagged  = agent_nxt.bad;
          out_data_nxt.sender_flagged = sender_nxt.bad;
          out_data_nxt.verdict_good   = !(agent_nxt.bad || sender_nxt.bad);
          // The verdict closes the message: start the next one from clean state.
          win_nxt    = '0;
          agent_nxt  = RegionRst;
          sender_nxt = RegionRst;
          ended_nxt  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      win_r     <= '0;
      agent_r   <= RegionRst;
      sender_r  <= RegionRst;
      ended_r   <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      win_r     <= win_nxt;
      agent_r   <= agent_nxt;
      sender_r  <= sender_nxt;
      ended_r   <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/header_blacklist_screen_test.sv =====
// Self-checking testbench for header_blacklist_screen: drives message bytes with random idling
// and stalls, and checks each verdict against a scoreboard that tracks both header regions.
// Depends on hbs_pkg and the header_blacklist_screen RTL.
module header_blacklist_screen_test;
  import hbs_pkg::*;

  class screen_scoreboard;
    logic [87:0] window;
    region_t     agent;
    region_t     sender;
    bit          text_done;
    out_item_t   verdict_q[$];
    int          errors;
    string       tool_names[8];

    function new();
      tool_names = '{"scan", "sipp", "sundayddr", "sipcli",
                     "sipsak", "sip-scan", "iWar", "sipvicious"};
      errors = 0;
      clear();
    endfunction

    function void clear();
      window    = '0;
      agent     = '{phase: PH_SEARCH, count: 4'd0, pending: 1'b0, bad: 1'b0};
      sender    = agent;
      text_done = 1'b0;
    endfunction

    // The newest byte sits in the low eight bits of the window.
    function bit window_ends_with(string s);
      int n = s.len();
      for (int k = 0; k < n; k++) begin
        if (window[8*(n-1-k) +: 8] != s[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit tool_name_seen(logic [3:0] cnt);
      foreach (tool_names[i]) begin
        if (tool_names[i].len() <= cnt && window_ends_with(tool_names[i])) return 1'b1;
      end
      return 1'b0;
    endfunction

    function region_t advance_region(region_t r, logic [7:0] b, string keyword);
      region_t n = r;
      if (r.phase == PH_SEARCH) begin
        if (window_ends_with(keyword)) begin
          n.phase   = PH_INSIDE;
          n.count   = 4'd0;
          n.pending = 1'b0;
        end
      end else if (r.phase == PH_INSIDE) begin
        if (b == 8'h0A) begin
          n.phase = PH_CLOSED;
          n.bad   = r.pending;
        end else begin
          if (r.count != 4'hF) n.count = r.count + 4'd1;
          if (tool_name_seen(n.count)) n.pending = 1'b1;
        end
      end
      return n;
    endfunction

    function void note_input(in_item_t it);
      out_item_t v;
      if (!text_done) begin
        if (it.text_byte == 8'h00) begin
          text_done = 1'b1;
        end else begin
          window = {window[79:0], it.text_byte};
          agent  = advance_region(agent, it.text_byte, "User-Agent:");
          sender = advance_region(sender, it.text_byte, "From:");
        end
      end
      if (it.end_of_message) begin
        v.verdict_good   = !(agent.bad || sender.bad);
        v.agent_flagged  = agent.bad;
        v.sender_flagged = sender.bad;
        verdict_q.push_back(v);
        clear();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %b", $time, got);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.verdict_good !== want.verdict_good) begin
        $display("%0t: verdict_good expected %b actual %b", $time,
                 want.verdict_good, got.verdict_good);
        errors++;
      end
      if (got.agent_flagged !== want.agent_flagged) begin
        $display("%0t: agent_flagged expected %b actual %b", $time,
                 want.agent_flagged, got.agent_flagged);
        errors++;
      end
      if (got.sender_flagged !== want.sender_flagged) begin
        $display("%0t: sender_flagged expected %b actual %b", $time,
                 want.sender_flagged, got.sender_flagged);
        errors++;
      end
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  screen_scoreboard sb = new();
  logic [7:0]       msg_q[$];
  string            tool_names[8] = '{"scan", "sipp", "sundayddr", "sipcli",
                                      "sipsak", "sip-scan", "iWar", "sipvicious"};
  int               cyc = 0;
  int               bytes_sent = 0;

  header_blacklist_screen uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  // A quiet window in the middle of the run with no idling on either side.
  function automatic bit idle_now();
    if (cyc >= 400 && cyc < 700) return 1'b0;
    return $urandom_range(0, 99) < 14;
  endfunction

  always @(negedge clk) out_stall <= idle_now();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t it;
    it.text_byte      = b;
    it.end_of_message = last;
    @(negedge clk);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic emit(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic emit_filler(int n);
    for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom_range(32, 126)));
  endtask

  // The end-of-message flag goes on the last byte of the queued message.
  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  // Region body: filler around an optional tool name, sometimes altered so that
  // it narrowly misses, and sometimes a second keyword inside the region.
  task automatic emit_region_body();
    string name;
    int    roll;
    emit_filler($urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(0, 5));
    if ($urandom_range(0, 9) < 6) begin
      name = tool_names[$urandom_range(0, 7)];
      roll = $urandom_range(0, 9);
      if (roll == 0) name[0] = name[0] ^ 8'h20;
      else if (roll == 1) name = name.substr(0, name.len() - 2);
      emit(name);
    end
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) != 0) emit("From:");
      else emit("User-Agent:");
    end
    emit_filler($urandom_range(0, 4));
  endtask

  task automatic build_message();
    int lines = $urandom_range(1, 4);
    int kind;
    for (int l = 0; l < lines; l++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        emit($urandom_range(0, 9) == 0 ? "User-agent:" : "User-Agent:");
        emit_region_body();
      end else if (kind < 70) begin
        emit($urandom_range(0, 9) == 0 ? "from:" : "From:");
        emit_region_body();
      end else if (kind < 85) begin
        emit("Via: ");
        emit_filler($urandom_range(0, 8));
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          msg_q.push_back(8'($urandom_range(1, 255)));
        end
      end
      // Leaving the last line open tests a region that is never closed.
      if (l != lines - 1 || $urandom_range(0, 4) != 0) msg_q.push_back(8'h0A);
    end
    if ($urandom_range(0, 9) == 0) msg_q.insert($urandom_range(0, msg_q.size()), 8'h00);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A closed sender region with a hit, where the final byte closes it.
    emit("From:iWar\n");
    send_message();
    // A one-byte message with every bit set.
    msg_q.push_back(8'hFF);
    send_message();
    // A zero byte ends the text, so the later newline cannot close the region.
    emit("From:sipp");
    msg_q.push_back(8'h00);
    msg_q.push_back(8'h0A);
    send_message();

    while (bytes_sent < 1200) begin
      build_message();
      send_message();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/hbs_pkg.sv
src/header_blacklist_screen.sv
test/header_blacklist_screen_test.sv
